// ===== hw/rtl/pls_pkg.sv =====
// shared types and codes for the positional list store
`timescale 1ns / 1ps

package pls_pkg;

  // request codes
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell does with its entry
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  localparam int unsigned POS_W = 5;
  localparam int unsigned LEN_W = 5;

  typedef struct packed {
    cmd_t               command;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [LEN_W-1:0]   length;
    status_t            status;
  } rsp_t;

endpackage

// ===== hw/rtl/pls_cell.sv =====
// one list slot: holds an entry, shifts with its neighbors on insert and remove
`timescale 1ns / 1ps

module pls_cell
  import pls_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 5
) (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic [IDX_W-1:0]   pos,
  input  logic signed [31:0] value,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] entry_o,
  output logic signed [31:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  // insert: slots above the position take the lower neighbor, the slot at it loads
  // remove: slots at or above the position take the upper neighbor
  always_comb begin
    entry_nxt = entry_r;
    case (op)
      CELL_INSERT: begin
        if (MyIdx > pos) begin
          entry_nxt = left_i;
        end else if (MyIdx == pos) begin
          entry_nxt = value;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= pos) begin
          entry_nxt = right_i;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

  // contribution to the read bus
  assign rd_o = (MyIdx == pos) ? entry_r : 32'sd0;

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// top level of the positional list store: request decode, cell row, result register
//
//   channel | signals                        | direction
//   in      | in_valid, in_ready, in_data    | request transaction into the block
//   out     | out_valid, out_ready, out_data | result transaction out of the block
//
// one request is taken per cycle; its result appears in the result register
// the next cycle. all cells shift or hold in parallel, so insert and remove
// finish as the result is registered. a new request is taken while the result
// register is empty or being drained; a stalled result holds back new requests.
// rst_n (synchronous) empties the list and the result register.
`timescale 1ns / 1ps

module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  rsp_t             out_data_r;

  logic               accept;
  cell_op_t           op;
  logic [IDX_W-1:0]   pos_ext;
  logic [IDX_W-1:0]   cnt_ext;
  logic [IDX_W-1:0]   cell_pos;
  logic               is_full;
  status_t            st;
  logic               rd_sel;
  logic signed [31:0] rd_bus;
  logic [IDX_W-1:0]   len_ext;

  logic signed [31:0] entry_w [DEPTH];
  logic signed [31:0] rd_w    [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_ext = IDX_W'(in_data.position);
  assign cnt_ext = IDX_W'(count_r);
  assign is_full = (count_r == Full);

  // request decode: range check before full check, rejects leave the list alone
  always_comb begin
    op        = CELL_HOLD;
    cell_pos  = pos_ext;
    st        = ST_OK;
    rd_sel    = 1'b0;
    count_nxt = count_r;
    case (in_data.command)
      CMD_APPEND: begin
        cell_pos = cnt_ext;
        if (is_full) begin
          st = ST_FULL;
        end else begin
          op        = CELL_INSERT;
          count_nxt = count_r + One;
        end
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st = ST_RANGE;
        end else if (is_full) begin
          st = ST_FULL;
        end else begin
          op        = CELL_INSERT;
          count_nxt = count_r + One;
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          op        = CELL_REMOVE;
          count_nxt = count_r - One;
        end
      end
      CMD_READ: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      default: st = ST_OK;
    endcase
    if (!accept) begin
      op        = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  // row of cells, each linked to its neighbors; the first takes the request value on its left
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = in_data.value;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    pls_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .pos     (cell_pos),
      .value   (in_data.value),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  // read bus: only the addressed cell drives a nonzero word
  always_comb begin
    rd_bus = 32'sd0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_w[i];
    end
  end

  assign len_ext = IDX_W'(count_nxt);

  // list length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.read_value <= rd_sel ? rd_bus : 32'sd0;
      out_data_r.length     <= len_ext[LEN_W-1:0];
      out_data_r.status     <= st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/pls_result_check.sv =====
// result checker for the positional list store: shadow list, expected results, compare
`timescale 1ns / 1ps

module pls_result_check
  import pls_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   errors,
  output int   pending
);

  // shadow copy of the list contents and its length
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_len;

  // results still owed by the block, oldest first
  rsp_t               owed_rsp_q [$];
  int                 mismatch_n = 0;

  // apply one request to the shadow list and return the result it should give
  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int   p;
    int   i;
    o.read_value = '0;
    o.status     = ST_OK;
    p            = int'(r.position);
    case (r.command)
      CMD_APPEND: begin
        if (shadow_len >= int'(DEPTH)) begin
          o.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = r.value;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        // bad position wins over full store
        if (p > shadow_len) begin
          o.status = ST_RANGE;
        end else if (shadow_len >= int'(DEPTH)) begin
          o.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = r.value;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (p >= shadow_len) begin
          o.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (p >= shadow_len) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = shadow_list[p];
        end
      end
    endcase
    o.length = LEN_W'(shadow_len);
    return o;
  endfunction

  // note one failure, with detail for the first few
  function automatic void report_mismatch(input rsp_t want, input rsp_t got, input bit orphan);
    mismatch_n++;
    if (mismatch_n <= 10) begin
      if (orphan)
        $display("%0t: result with no request owed: value %0d length %0d status %0d",
                 $time, got.read_value, got.length, got.status);
      else
        $display("%0t: result mismatch: want value %0d length %0d status %0d, got %0d %0d %0d",
                 $time, want.read_value, want.length, want.status,
                 got.read_value, got.length, got.status);
    end
  endfunction

  // track both channels; requests are pushed before results are popped
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      shadow_len = 0;
      owed_rsp_q.delete();
    end else begin
      if (in_valid && in_ready) owed_rsp_q.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch('0, out_data, 1'b1);
        end else begin
          want = owed_rsp_q.pop_front();
          if (out_data.read_value !== want.read_value || out_data.length !== want.length ||
              out_data.status !== want.status)
            report_mismatch(want, out_data, 1'b0);
        end
      end
    end
    errors  <= mismatch_n;
    pending <= owed_rsp_q.size();
  end

endmodule

// ===== sim/tb_positional_list_store.sv =====
// testbench top for the positional list store: clock, reset, request and result traffic
`timescale 1ns / 1ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int          HOLD_AFTER   = 600;
  localparam int          HOLD_CYCLES  = 80;

  localparam int GROW   = 0;
  localparam int SHRINK = 1;
  localparam int MIXED  = 2;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  int   fail_count;
  int   rsp_pending;
  int   sent_n;
  int   len_est;
  bit   hold_done;

  positional_list_store #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pls_result_check #(.DEPTH(DEPTH)) u_result_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (fail_count),
    .pending  (rsp_pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb_positional_list_store: errors");
    $finish;
  end

  function automatic req_t make_request(input cmd_t c, input int p, input logic [31:0] v);
    req_t r;
    r.command  = c;
    r.position = POS_W'(p);
    r.value    = v;
    return r;
  endfunction

  // rough list length, only used to steer positions into range
  function automatic void track_length(input req_t r);
    int p;
    p = int'(r.position);
    case (r.command)
      CMD_APPEND: if (len_est < int'(DEPTH)) len_est++;
      CMD_INSERT: if (p <= len_est && len_est < int'(DEPTH)) len_est++;
      CMD_REMOVE: if (p < len_est) len_est--;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // random request, command mix set by the bias, positions mostly inside the list
  function automatic req_t pick_request(input int bias);
    int   roll;
    int   p;
    cmd_t c;
    roll = $urandom_range(0, 99);
    if (bias == GROW)
      c = cmd_t'(roll < 35 ? CMD_APPEND : roll < 70 ? CMD_INSERT :
                 roll < 80 ? CMD_REMOVE : CMD_READ);
    else if (bias == SHRINK)
      c = cmd_t'(roll < 10 ? CMD_APPEND : roll < 20 ? CMD_INSERT :
                 roll < 70 ? CMD_REMOVE : CMD_READ);
    else
      c = cmd_t'(roll < 25 ? CMD_APPEND : roll < 50 ? CMD_INSERT :
                 roll < 75 ? CMD_REMOVE : CMD_READ);
    if (c == CMD_APPEND || $urandom_range(0, 6) == 0)
      p = $urandom_range(0, DEPTH);
    else if (c == CMD_INSERT)
      p = $urandom_range(0, len_est);
    else if (len_est > 0)
      p = $urandom_range(0, len_est - 1);
    else
      p = $urandom_range(0, DEPTH);
    return make_request(c, p, pick_value());
  endfunction

  // offer one request, hold it until taken, then optionally go quiet
  task automatic offer_request(input req_t r, input int gap);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_n++;
    track_length(r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: stretches of steady, random, sparse and patterned ready, plus one long hold-off
  initial begin
    int mode;
    int span;
    int k;
    out_ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      if (!hold_done && sent_n >= HOLD_AFTER) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
      end
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 3 != 0);
        endcase
      end
    end
  end

  // request side: reset, directed cases, random bursts, drain, verdict
  initial begin
    int left;
    int burst;
    int bias;
    int k;
    int gap;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    sent_n   = 0;
    len_est  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: read, remove and insert past the end are all rejected
    offer_request(make_request(CMD_READ, 0, 32'h0), $urandom_range(0, 1));
    offer_request(make_request(CMD_REMOVE, 0, 32'h0), $urandom_range(0, 1));
    offer_request(make_request(CMD_INSERT, 1, 32'h1234_5678), $urandom_range(0, 1));
    // single entry, then removing the only entry
    offer_request(make_request(CMD_APPEND, 0, 32'h8000_0000), $urandom_range(0, 1));
    offer_request(make_request(CMD_REMOVE, 0, 32'h0), $urandom_range(0, 1));
    // insert at head and at the tail position
    offer_request(make_request(CMD_INSERT, 0, 32'h7fff_ffff), $urandom_range(0, 1));
    offer_request(make_request(CMD_INSERT, 1, 32'hffff_ffff), $urandom_range(0, 1));
    offer_request(make_request(CMD_READ, 1, 32'h0), $urandom_range(0, 1));
    offer_request(make_request(CMD_READ, 2, 32'h0), $urandom_range(0, 1));
    // fill to the top
    for (k = 0; k < int'(DEPTH) - 2; k++)
      offer_request(make_request(CMD_APPEND, DEPTH, pick_value()), 0);
    // full store on append and on insert at a legal position, read past the end
    offer_request(make_request(CMD_APPEND, 0, 32'h5a5a_5a5a), $urandom_range(0, 1));
    offer_request(make_request(CMD_INSERT, DEPTH, 32'ha5a5_a5a5), $urandom_range(0, 1));
    offer_request(make_request(CMD_READ, DEPTH, 32'h0), $urandom_range(0, 1));
    offer_request(make_request(CMD_READ, DEPTH - 1, 32'h0), $urandom_range(0, 1));

    // random bursts with gaps, bias drifting between growing and shrinking
    left = RANDOM_ITEMS;
    bias = GROW;
    while (left > 0) begin
      if ($urandom_range(0, 3) == 0) bias = $urandom_range(GROW, MIXED);
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (k = 0; k < burst; k++) begin
        gap = 0;
        if (k == burst - 1 && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        offer_request(pick_request(bias), gap);
      end
      left -= burst;
    end

    // let every owed result come out, then idle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (rsp_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && rsp_pending == 0)
      $display("tb_positional_list_store: clean");
    else
      $display("tb_positional_list_store: errors");
    $finish;
  end

endmodule
